// ===== sv/rps_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes, reset values and sequencer states for the reflow setpoint block
package rps_pkg;

  // field widths
  localparam int TEMP_W     = 13;
  localparam int RAMP_W     = 8;
  localparam int SECS_W     = 10;
  localparam int TIN_W      = 16;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // internal datapath widths
  localparam int TIME_W    = 21;  // signed time in 1/16 s
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 18;
  localparam int DIV_Q_W   = 37;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int MUL_A_W   = 15;
  localparam int MUL_B_W   = 21;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int RAW_W     = 38;

  // profile constants
  localparam int TEMP_MAX_VAL = 8191;
  localparam int SOAK_TAIL    = 160;   // last 10 s of soak, also 10 C below liquidus
  localparam int SHORT_SOAK   = 10;
  localparam int ONE_SEC      = 16;
  localparam int RL_BASE      = 1040;  // 65 s
  localparam int RL_MIN       = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_TEMP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIQUIDUS_TEMP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_TEMP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_RAMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_RAMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOAK_SECONDS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_SECONDS = 3'd6;

  // register reset values
  localparam logic [TEMP_W-1:0] RST_PREHEAT_TEMP  = 13'd2160;
  localparam logic [TEMP_W-1:0] RST_LIQUIDUS_TEMP = 13'd2928;
  localparam logic [TEMP_W-1:0] RST_PEAK_TEMP     = 13'd3520;
  localparam logic [RAMP_W-1:0] RST_PREHEAT_RAMP  = 8'd24;
  localparam logic [RAMP_W-1:0] RST_COOLDOWN_RAMP = 8'd48;
  localparam logic [SECS_W-1:0] RST_SOAK_SECONDS  = 10'd120;
  localparam logic [SECS_W-1:0] RST_DWELL_SECONDS = 10'd30;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_PREHEAT  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SOAK     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_REFLOW   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DWELL    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COOLDOWN = 3'd4;

  typedef logic signed [TIME_W-1:0] time_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PE_START,
    ST_PE_WAIT,
    ST_RL_START,
    ST_RL_WAIT,
    ST_DERIVE,
    ST_OFFSET,
    ST_MUL,
    ST_PROD,
    ST_DIV_WAIT,
    ST_FINISH
  } st_t;

endpackage

// ===== sv/rps_div.sv =====
`timescale 1ns / 1ps
// shared floor divider: signed numerator, positive denominator, one quotient bit per cycle
module rps_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rps_pkg::DIV_NUM_W-1:0] num,
  input  logic        [rps_pkg::DIV_DEN_W-1:0] den,
  output logic                                 done,
  output logic signed [rps_pkg::DIV_Q_W-1:0]   quot
);

  localparam int NUM_W = rps_pkg::DIV_NUM_W;
  localparam int DEN_W = rps_pkg::DIV_DEN_W;
  localparam int Q_W   = rps_pkg::DIV_Q_W;
  localparam int CNT_W = rps_pkg::DIV_CNT_W;

  logic              busy;
  logic              fin;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  qr;
  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic signed [Q_W-1:0] qpos;
  logic signed [Q_W-1:0] res;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem, qr[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // round toward minus infinity for negative numerators
  assign qpos = $signed({1'b0, qr});
  assign res  = neg ? (-qpos - Q_W'(rem != '0)) : qpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      qr    <= mag;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qr  <= {qr[NUM_W-2:0], ge};
    end
    if (fin) begin
      quot <= res;
    end
  end

endmodule

// ===== sv/rps_mul.sv =====
`timescale 1ns / 1ps
// shared signed multiplier with registered product
module rps_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rps_pkg::MUL_A_W-1:0] a,
  input  logic signed [rps_pkg::MUL_B_W-1:0] b,
  output logic signed [rps_pkg::MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== sv/reflow_profile_setpoint.sv =====
`timescale 1ns / 1ps
// reflow profile setpoint: each accepted sample steps through the offset, multiply and product
// states, then a divide wait when the step divides (soak ramp, reflow), then finish; the
// divider resolves one quotient bit per cycle of its 36-bit numerator; the first transaction
// after reset or any config write also runs the two divisions that derive the phase boundaries,
// which are then cached; one transaction at a time, the next taken the cycle after the result loads
// synchronous reset: profile registers to defaults, phase to preheat, no result held
module reflow_profile_setpoint (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [rps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rps_pkg::TIN_W-1:0]           time_seconds,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rps_pkg::TEMP_W-1:0]          target_temp,
  output logic [rps_pkg::PHASE_W-1:0]         phase_now
);

  localparam int TIME_W = rps_pkg::TIME_W;
  localparam int NUM_W  = rps_pkg::DIV_NUM_W;
  localparam int DEN_W  = rps_pkg::DIV_DEN_W;
  localparam int A_W    = rps_pkg::MUL_A_W;
  localparam int B_W    = rps_pkg::MUL_B_W;
  localparam int P_W    = rps_pkg::MUL_P_W;
  localparam int RAW_W  = rps_pkg::RAW_W;
  localparam int TEMP_W = rps_pkg::TEMP_W;
  localparam int SECS_W = rps_pkg::SECS_W;
  localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(rps_pkg::TEMP_MAX_VAL);

  // profile registers
  logic [TEMP_W-1:0]           preheat_temp;
  logic [TEMP_W-1:0]           liquidus_temp;
  logic [TEMP_W-1:0]           peak_temp;
  logic [rps_pkg::RAMP_W-1:0]  preheat_ramp;
  logic [rps_pkg::RAMP_W-1:0]  cooldown_ramp;
  logic [SECS_W-1:0]           soak_seconds;
  logic [SECS_W-1:0]           dwell_seconds;

  // sequencer and state
  rps_pkg::st_t                state;
  rps_pkg::st_t                state_next;
  logic [rps_pkg::PHASE_W-1:0] phase;
  logic [rps_pkg::PHASE_W-1:0] phase_upd;
  logic                        deriv_ok;

  // cached phase boundaries, 1/16 s
  rps_pkg::time_t pe;
  rps_pkg::time_t rl;
  rps_pkg::time_t se;
  rps_pkg::time_t ser;
  rps_pkg::time_t de;

  // per transaction
  logic [rps_pkg::TIN_W-1:0] secs;
  rps_pkg::time_t t_now;
  rps_pkg::time_t d_pe;
  rps_pkg::time_t d_se;
  rps_pkg::time_t d_de;
  rps_pkg::time_t se_tail;
  rps_pkg::time_t soak16;
  rps_pkg::time_t dwell16;
  rps_pkg::time_t rl_raw;
  rps_pkg::time_t rl_val;
  rps_pkg::time_t se_sum;
  rps_pkg::time_t ser_sum;
  rps_pkg::time_t de_sum;

  logic [rps_pkg::RAMP_W-1:0] pr_eff;
  logic [rps_pkg::RAMP_W-1:0] cr_eff;
  logic signed [TEMP_W:0]     pk_liq;
  logic signed [A_W-1:0]      soak_rise;
  logic [SECS_W-1:0]          soak_less;
  logic [DEN_W-1:0]           soak_den;

  logic signed [A_W-1:0] mul_a;
  logic signed [A_W-1:0] mul_a_next;
  logic signed [B_W-1:0] mul_b;
  logic signed [B_W-1:0] mul_b_next;
  logic signed [P_W-1:0] prod;
  logic                  adv;
  logic                  adv_next;
  logic                  soak_hi;
  logic                  soak_hi_next;
  logic                  needs_div;

  // shared divider
  logic                              div_start;
  logic                              div_done;
  logic signed [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]                  div_den;
  logic signed [rps_pkg::DIV_Q_W-1:0] div_quot;

  // load strobes
  logic mul_en;
  logic ld_pe;
  logic ld_rl;
  logic ld_derive;
  logic ld_offset;
  logic ld_out;
  logic out_free;

  logic signed [RAW_W-1:0] raw_temp;
  logic [TEMP_W-1:0]       temp_sat;

  // zero ramps count as one
  assign pr_eff = (preheat_ramp == '0) ? rps_pkg::RAMP_W'(1) : preheat_ramp;
  assign cr_eff = (cooldown_ramp == '0) ? rps_pkg::RAMP_W'(1) : cooldown_ramp;

  assign pk_liq    = $signed({1'b0, peak_temp}) - $signed({1'b0, liquidus_temp});
  // soak top minus preheat temperature
  assign soak_rise = $signed({2'b00, liquidus_temp}) - $signed({2'b00, preheat_temp})
                     - A_W'(rps_pkg::SOAK_TAIL);

  // soak slope divisor, one second for short soaks
  assign soak_less = soak_seconds - SECS_W'(rps_pkg::SHORT_SOAK);
  assign soak_den  = (soak_seconds > SECS_W'(rps_pkg::SHORT_SOAK)) ?
                     {4'b0000, soak_less, 4'b0000} : DEN_W'(rps_pkg::ONE_SEC);

  assign t_now   = TIME_W'({secs, 4'b0000});
  assign soak16  = TIME_W'({soak_seconds, 4'b0000});
  assign dwell16 = TIME_W'({dwell_seconds, 4'b0000});
  assign d_pe    = t_now - pe;
  assign d_se    = t_now - se;
  assign d_de    = t_now - de;
  assign se_tail = se - TIME_W'(rps_pkg::SOAK_TAIL);

  // reflow length from the cooldown-rate quotient, floored at one second
  assign rl_raw = TIME_W'(rps_pkg::RL_BASE) - dwell16 - $signed(div_quot[TIME_W-1:0]);
  assign rl_val = (rl_raw < TIME_W'(rps_pkg::RL_MIN)) ? TIME_W'(rps_pkg::RL_MIN) : rl_raw;

  assign se_sum  = pe + soak16;
  assign ser_sum = se_sum + rl;
  assign de_sum  = ser_sum + dwell16;

  assign needs_div = ((phase == rps_pkg::PH_SOAK) && !soak_hi) ||
                     (phase == rps_pkg::PH_REFLOW);
  assign out_free  = !out_valid || out_ready;

  // multiplier operands and advance test for the current phase
  always_comb begin
    mul_a_next   = '0;
    mul_b_next   = '0;
    adv_next     = 1'b0;
    soak_hi_next = t_now > se_tail;
    unique case (phase)
      rps_pkg::PH_PREHEAT: begin
        mul_a_next = A_W'(pr_eff);
        mul_b_next = B_W'(secs);
        adv_next   = t_now > pe;
      end
      rps_pkg::PH_SOAK: begin
        mul_a_next = soak_rise;
        mul_b_next = d_pe;
        adv_next   = t_now > se;
      end
      rps_pkg::PH_REFLOW: begin
        mul_a_next = A_W'(pk_liq);
        mul_b_next = d_se;
        adv_next   = t_now > ser;
      end
      rps_pkg::PH_DWELL: begin
        adv_next = t_now > de;
      end
      rps_pkg::PH_COOLDOWN: begin
        mul_a_next = A_W'(cr_eff);
        mul_b_next = d_de;
      end
      default: begin
        adv_next = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = deriv_ok ? rps_pkg::ST_OFFSET : rps_pkg::ST_PE_START;
        end
      end
      rps_pkg::ST_PE_START: state_next = rps_pkg::ST_PE_WAIT;
      rps_pkg::ST_PE_WAIT: begin
        if (div_done) begin
          state_next = rps_pkg::ST_RL_START;
        end
      end
      rps_pkg::ST_RL_START: state_next = rps_pkg::ST_RL_WAIT;
      rps_pkg::ST_RL_WAIT: begin
        if (div_done) begin
          state_next = rps_pkg::ST_DERIVE;
        end
      end
      rps_pkg::ST_DERIVE: state_next = rps_pkg::ST_OFFSET;
      rps_pkg::ST_OFFSET: state_next = rps_pkg::ST_MUL;
      rps_pkg::ST_MUL:    state_next = rps_pkg::ST_PROD;
      rps_pkg::ST_PROD: begin
        state_next = needs_div ? rps_pkg::ST_DIV_WAIT : rps_pkg::ST_FINISH;
      end
      rps_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = rps_pkg::ST_FINISH;
        end
      end
      rps_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rps_pkg::ST_IDLE;
        end
      end
      default: state_next = rps_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_en    = 1'b0;
    ld_pe     = 1'b0;
    ld_rl     = 1'b0;
    ld_derive = 1'b0;
    ld_offset = 1'b0;
    ld_out    = 1'b0;
    unique case (state)
      rps_pkg::ST_IDLE: in_ready = 1'b1;
      rps_pkg::ST_PE_START: begin
        // preheat end = preheat temperature * 16 / ramp
        div_start = 1'b1;
        div_num   = NUM_W'({1'b0, preheat_temp, 4'b0000});
        div_den   = DEN_W'(pr_eff);
      end
      rps_pkg::ST_PE_WAIT: ld_pe = div_done;
      rps_pkg::ST_RL_START: begin
        // cooldown time from peak to liquidus
        div_start = 1'b1;
        div_num   = NUM_W'($signed({pk_liq, 4'b0000}));
        div_den   = DEN_W'(cr_eff);
      end
      rps_pkg::ST_RL_WAIT: ld_rl = div_done;
      rps_pkg::ST_DERIVE:  ld_derive = 1'b1;
      rps_pkg::ST_OFFSET:  ld_offset = 1'b1;
      rps_pkg::ST_MUL:     mul_en = 1'b1;
      rps_pkg::ST_PROD: begin
        div_start = needs_div;
        div_num   = prod;
        div_den   = (phase == rps_pkg::PH_REFLOW) ? rl[DEN_W-1:0] : soak_den;
      end
      rps_pkg::ST_DIV_WAIT: in_ready = 1'b0;
      rps_pkg::ST_FINISH:   ld_out = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // target for the phase the transaction started in
  always_comb begin
    raw_temp = '0;
    unique case (phase)
      rps_pkg::PH_PREHEAT: raw_temp = RAW_W'(prod);
      rps_pkg::PH_SOAK: begin
        if (soak_hi) begin
          // step toward liquidus at one sixteenth degree per sixteenth second
          raw_temp = RAW_W'(liquidus_temp) + RAW_W'(d_se);
        end else begin
          raw_temp = RAW_W'(preheat_temp) + RAW_W'(div_quot);
        end
      end
      rps_pkg::PH_REFLOW:   raw_temp = RAW_W'(liquidus_temp) + RAW_W'(div_quot);
      rps_pkg::PH_DWELL:    raw_temp = RAW_W'(peak_temp);
      rps_pkg::PH_COOLDOWN: raw_temp = RAW_W'(peak_temp) - RAW_W'(prod >>> 4);
      default:              raw_temp = '0;
    endcase
  end

  // saturate to the output range
  always_comb begin
    priority if (raw_temp < 0) begin
      temp_sat = '0;
    end else if (raw_temp > RAW_MAX) begin
      temp_sat = RAW_MAX[TEMP_W-1:0];
    end else begin
      temp_sat = raw_temp[TEMP_W-1:0];
    end
  end

  // at most one phase forward per transaction
  assign phase_upd = adv ? (phase + 1'b1) : phase;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rps_pkg::ST_IDLE;
      phase         <= rps_pkg::PH_PREHEAT;
      deriv_ok      <= 1'b0;
      out_valid     <= 1'b0;
      preheat_temp  <= rps_pkg::RST_PREHEAT_TEMP;
      liquidus_temp <= rps_pkg::RST_LIQUIDUS_TEMP;
      peak_temp     <= rps_pkg::RST_PEAK_TEMP;
      preheat_ramp  <= rps_pkg::RST_PREHEAT_RAMP;
      cooldown_ramp <= rps_pkg::RST_COOLDOWN_RAMP;
      soak_seconds  <= rps_pkg::RST_SOAK_SECONDS;
      dwell_seconds <= rps_pkg::RST_DWELL_SECONDS;
    end else begin
      state <= state_next;
      if (ld_out) begin
        phase     <= phase_upd;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // any write makes the cached boundaries stale
      if (cfg_wen) begin
        deriv_ok <= 1'b0;
      end else if (ld_derive) begin
        deriv_ok <= 1'b1;
      end
      if (cfg_wen) begin
        unique case (cfg_index)
          rps_pkg::REG_PREHEAT_TEMP:  preheat_temp  <= cfg_data[TEMP_W-1:0];
          rps_pkg::REG_LIQUIDUS_TEMP: liquidus_temp <= cfg_data[TEMP_W-1:0];
          rps_pkg::REG_PEAK_TEMP:     peak_temp     <= cfg_data[TEMP_W-1:0];
          rps_pkg::REG_PREHEAT_RAMP:  preheat_ramp  <= cfg_data[rps_pkg::RAMP_W-1:0];
          rps_pkg::REG_COOLDOWN_RAMP: cooldown_ramp <= cfg_data[rps_pkg::RAMP_W-1:0];
          rps_pkg::REG_SOAK_SECONDS:  soak_seconds  <= cfg_data[SECS_W-1:0];
          rps_pkg::REG_DWELL_SECONDS: dwell_seconds <= cfg_data[SECS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      secs <= time_seconds;
    end
    if (ld_pe) begin
      pe <= $signed(div_quot[TIME_W-1:0]);
    end
    if (ld_rl) begin
      rl <= rl_val;
    end
    if (ld_derive) begin
      se  <= se_sum;
      ser <= ser_sum;
      de  <= de_sum;
    end
    if (ld_offset) begin
      mul_a   <= mul_a_next;
      mul_b   <= mul_b_next;
      adv     <= adv_next;
      soak_hi <= soak_hi_next;
    end
    if (ld_out) begin
      target_temp <= temp_sat;
      phase_now   <= phase_upd;
    end
  end

  rps_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

// ===== sim/tb_reflow_profile_setpoint.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the reflow profile setpoint block, one walk through all phases
module tb_reflow_profile_setpoint;

  localparam int     CLK_PERIOD       = 8;
  localparam int     RESET_CYCLES     = 8;
  localparam int     LONG_HOLD_CYCLES = 400;
  localparam int     SETTLE_CYCLES    = 200;
  localparam longint TIMEOUT_CYCLES   = 2000000;
  localparam int     REPORT_LIMIT     = 10;
  localparam int     TAIL_WINDOW      = 12;

  localparam int TIN_W        = rps_pkg::TIN_W;
  localparam int TEMP_W       = rps_pkg::TEMP_W;
  localparam int PHASE_W      = rps_pkg::PHASE_W;
  localparam int RAMP_W       = rps_pkg::RAMP_W;
  localparam int SECS_W       = rps_pkg::SECS_W;
  localparam int CFG_IDX_W    = rps_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = rps_pkg::CFG_DATA_W;
  localparam int TEMP_MAX_VAL = rps_pkg::TEMP_MAX_VAL;
  localparam int ONE_SEC      = rps_pkg::ONE_SEC;
  localparam int RL_BASE      = rps_pkg::RL_BASE;
  localparam int RL_MIN       = rps_pkg::RL_MIN;
  localparam int SOAK_TAIL    = rps_pkg::SOAK_TAIL;
  localparam int SHORT_SOAK   = rps_pkg::SHORT_SOAK;

  // index with no register behind it, writes to it change no profile register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_wen      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [TIN_W-1:0]      time_seconds = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [TEMP_W-1:0]     target_temp;
  logic [PHASE_W-1:0]    phase_now;

  reflow_profile_setpoint DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .time_seconds (time_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .target_temp  (target_temp),
    .phase_now    (phase_now)
  );

  // predicted profile registers and phase
  logic [TEMP_W-1:0]  prof_preheat_temp;
  logic [TEMP_W-1:0]  prof_liquidus_temp;
  logic [TEMP_W-1:0]  prof_peak_temp;
  logic [RAMP_W-1:0]  prof_preheat_ramp;
  logic [RAMP_W-1:0]  prof_cooldown_ramp;
  logic [SECS_W-1:0]  prof_soak_seconds;
  logic [SECS_W-1:0]  prof_dwell_seconds;
  logic [PHASE_W-1:0] prof_phase;

  typedef struct packed {
    logic [TIN_W-1:0]   secs;
    logic [TEMP_W-1:0]  temp;
    logic [PHASE_W-1:0] phase;
  } setpoint_t;

  setpoint_t expected_setpoints[$];

  int fail_count   = 0;
  bit hold_off_req = 1'b0;
  bit burst_mode   = 1'b0;
  int stall_left   = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_reflow_profile_setpoint: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [TEMP_W-1:0] clamp_temp(longint v);
    if (v < 0) return '0;
    if (v > TEMP_MAX_VAL) return TEMP_W'(TEMP_MAX_VAL);
    return TEMP_W'(v);
  endfunction

  // phase boundaries in 1/16 s: preheat end, soak end, reflow length, dwell end
  task automatic profile_bounds(output longint pe, output longint se, output longint rl,
                                output longint de);
    longint pre, liq, pk, pr, cr, soak, dwell;
    pre   = longint'(prof_preheat_temp);
    liq   = longint'(prof_liquidus_temp);
    pk    = longint'(prof_peak_temp);
    pr    = longint'(prof_preheat_ramp);
    cr    = longint'(prof_cooldown_ramp);
    soak  = longint'(prof_soak_seconds);
    dwell = longint'(prof_dwell_seconds);
    // zero ramps count as one
    if (pr == 0) pr = 1;
    if (cr == 0) cr = 1;
    pe = floor_div(pre * ONE_SEC, pr);
    se = pe + ONE_SEC * soak;
    rl = RL_BASE - ONE_SEC * dwell - floor_div((pk - liq) * ONE_SEC, cr);
    if (rl < RL_MIN) rl = RL_MIN;
    de = se + rl + ONE_SEC * dwell;
  endtask

  // target for one time sample, advancing the phase by at most one step
  task automatic step_profile(input logic [TIN_W-1:0] secs, output setpoint_t res);
    longint pe, se, rl, de;
    longint s, t, pre, liq, pk, pr, cr, soak_top, den, tgt;
    profile_bounds(pe, se, rl, de);
    s        = longint'(secs);
    t        = s * ONE_SEC;
    pre      = longint'(prof_preheat_temp);
    liq      = longint'(prof_liquidus_temp);
    pk       = longint'(prof_peak_temp);
    pr       = longint'(prof_preheat_ramp);
    cr       = longint'(prof_cooldown_ramp);
    if (pr == 0) pr = 1;
    if (cr == 0) cr = 1;
    soak_top = liq - SOAK_TAIL;
    case (prof_phase)
      rps_pkg::PH_PREHEAT: begin
        tgt = s * pr;
        if (t > pe) prof_phase = rps_pkg::PH_SOAK;
      end
      rps_pkg::PH_SOAK: begin
        if (t > se - SOAK_TAIL) begin
          // last ten seconds climb one unit per 1/16 s toward liquidus
          tgt = soak_top + (t - (se - SOAK_TAIL));
        end else begin
          den = ONE_SEC * (longint'(prof_soak_seconds) - SHORT_SOAK);
          if (den < ONE_SEC) den = ONE_SEC;
          tgt = pre + floor_div((soak_top - pre) * (t - pe), den);
        end
        if (t > se) prof_phase = rps_pkg::PH_REFLOW;
      end
      rps_pkg::PH_REFLOW: begin
        tgt = liq + floor_div((pk - liq) * (t - se), rl);
        if (t > se + rl) prof_phase = rps_pkg::PH_DWELL;
      end
      rps_pkg::PH_DWELL: begin
        tgt = pk;
        if (t > de) prof_phase = rps_pkg::PH_COOLDOWN;
      end
      rps_pkg::PH_COOLDOWN: begin
        tgt = pk - floor_div(cr * (t - de), ONE_SEC);
      end
      default: begin
        tgt = 0;
      end
    endcase
    res.secs  = secs;
    res.temp  = clamp_temp(tgt);
    res.phase = prof_phase;
  endtask

  // span of times in whole seconds: from the start of the current phase up to the
  // last time that still keeps it
  task automatic phase_window(output int lo, output int hi);
    longint pe, se, rl, de;
    profile_bounds(pe, se, rl, de);
    case (prof_phase)
      rps_pkg::PH_PREHEAT: begin
        lo = 0;
        hi = int'(pe / ONE_SEC);
      end
      rps_pkg::PH_SOAK: begin
        lo = int'(pe / ONE_SEC);
        hi = int'(se / ONE_SEC);
      end
      rps_pkg::PH_REFLOW: begin
        lo = int'(se / ONE_SEC);
        hi = int'((se + rl) / ONE_SEC);
      end
      rps_pkg::PH_DWELL: begin
        lo = int'((se + rl) / ONE_SEC);
        hi = int'(de / ONE_SEC);
      end
      default: begin
        lo = (de / ONE_SEC > 65535) ? 65535 : int'(de / ONE_SEC);
        hi = 65535;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_setpoints
    setpoint_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_setpoints.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("%0t: unexpected result temp %0d phase %0d", $realtime, target_temp,
                   phase_now);
        fail_count++;
      end else begin
        want = expected_setpoints.pop_front();
        if (target_temp !== want.temp) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: time %0d target_temp expected %0d got %0d", $realtime,
                     want.secs, want.temp, target_temp);
          fail_count++;
        end
        if (phase_now !== want.phase) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: time %0d phase_now expected %0d got %0d", $realtime,
                     want.secs, want.phase, phase_now);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls, a long hold when asked, always ready in burst stretches
  initial begin : receiver
    int r;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req && !held) begin
        out_ready  <= 1'b0;
        stall_left = LONG_HOLD_CYCLES;
        held       = 1'b1;
      end else if (burst_mode) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(3, 0) : $urandom_range(60, 10);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender side

  function automatic int sender_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one time sample, predict it once accepted
  task automatic offer_time(input logic [TIN_W-1:0] secs);
    setpoint_t exp_sp;
    int        gap;
    in_valid     <= 1'b1;
    time_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    step_profile(secs, exp_sp);
    expected_setpoints.push_back(exp_sp);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering until every predicted setpoint has come back
  task automatic wait_for_setpoints();
    in_valid <= 1'b0;
    while (expected_setpoints.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rps_pkg::REG_PREHEAT_TEMP:  prof_preheat_temp  = data[TEMP_W-1:0];
      rps_pkg::REG_LIQUIDUS_TEMP: prof_liquidus_temp = data[TEMP_W-1:0];
      rps_pkg::REG_PEAK_TEMP:     prof_peak_temp     = data[TEMP_W-1:0];
      rps_pkg::REG_PREHEAT_RAMP:  prof_preheat_ramp  = data[RAMP_W-1:0];
      rps_pkg::REG_COOLDOWN_RAMP: prof_cooldown_ramp = data[RAMP_W-1:0];
      rps_pkg::REG_SOAK_SECONDS:  prof_soak_seconds  = data[SECS_W-1:0];
      rps_pkg::REG_DWELL_SECONDS: prof_dwell_seconds = data[SECS_W-1:0];
      default: ;
    endcase
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // every register gets zero, all ones or random bits; upper bits beyond a
  // register's width are driven too
  task automatic randomize_profile();
    int r;
    logic [CFG_DATA_W-1:0] value;
    for (int i = rps_pkg::REG_PREHEAT_TEMP; i <= rps_pkg::REG_DWELL_SECONDS; i++) begin
      r = $urandom_range(9, 0);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      else value = CFG_DATA_W'($urandom);
      write_reg(CFG_IDX_W'(i), value);
    end
    if ($urandom_range(3, 0) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    burst_mode = ($urandom_range(3, 0) == 0);
  endtask

  // mostly inside the phase, some near its end, the rest from time zero on
  function automatic logic [TIN_W-1:0] pick_time(int lo, int hi);
    int r;
    int tail_lo;
    r       = $urandom_range(99, 0);
    tail_lo = (hi - TAIL_WINDOW > lo) ? hi - TAIL_WINDOW : lo;
    if (r < 60) return TIN_W'($urandom_range(hi, lo));
    if (r < 80) return TIN_W'($urandom_range(hi, tail_lo));
    return TIN_W'($urandom_range(hi, 0));
  endfunction

  // batches under fresh random profiles, no time past the end of the current phase
  task automatic run_random(input int n_batches, input int per_batch);
    int lo, hi;
    repeat (n_batches) begin
      wait_for_setpoints();
      randomize_profile();
      phase_window(lo, hi);
      repeat (per_batch) offer_time(pick_time(lo, hi));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_preheat();
    int lo, hi;
    phase_window(lo, hi);
    offer_time('0);
    offer_time(TIN_W'(hi));          // at preheat end, stays
    offer_time(TIN_W'(hi / 2));      // time going backward
    // zero preheat ramp with the hottest preheat end
    wait_for_setpoints();
    write_reg(rps_pkg::REG_PREHEAT_TEMP, '1);
    write_reg(rps_pkg::REG_PREHEAT_RAMP, '0);
    phase_window(lo, hi);
    offer_time(TIN_W'(hi));
    offer_time(TIN_W'(1));
    run_random(6, 50);
    // latest time: ramp saturates and soak begins
    offer_time('1);
  endtask

  task automatic test_soak();
    int lo, hi;
    phase_window(lo, hi);
    offer_time(TIN_W'(lo));
    offer_time(TIN_W'(hi));
    // short soak: slope divisor falls back to one second
    wait_for_setpoints();
    write_reg(rps_pkg::REG_SOAK_SECONDS, CFG_DATA_W'(SHORT_SOAK));
    phase_window(lo, hi);
    offer_time('0);
    offer_time(TIN_W'(hi));
    wait_for_setpoints();
    write_reg(rps_pkg::REG_SOAK_SECONDS, '0);
    offer_time('0);
    // longest soak, both sides of the final ten seconds
    wait_for_setpoints();
    write_reg(rps_pkg::REG_SOAK_SECONDS, '1);
    phase_window(lo, hi);
    offer_time(TIN_W'((lo + hi) / 2));
    offer_time(TIN_W'(hi - SHORT_SOAK));
    offer_time(TIN_W'(hi - SHORT_SOAK + 1));
    run_random(8, 50);
    phase_window(lo, hi);
    offer_time(TIN_W'(hi + 1));
  endtask

  task automatic test_reflow();
    int lo, hi;
    // peak below liquidus with a zero cooldown ramp: long reflow, falling target
    wait_for_setpoints();
    write_reg(rps_pkg::REG_PEAK_TEMP, '0);
    write_reg(rps_pkg::REG_LIQUIDUS_TEMP, '1);
    write_reg(rps_pkg::REG_COOLDOWN_RAMP, '0);
    phase_window(lo, hi);
    offer_time(TIN_W'(lo));
    offer_time(TIN_W'((lo + hi) / 2));
    offer_time(TIN_W'(hi));
    // reflow length floored at one second
    wait_for_setpoints();
    write_reg(rps_pkg::REG_PEAK_TEMP, '1);
    write_reg(rps_pkg::REG_LIQUIDUS_TEMP, '0);
    write_reg(rps_pkg::REG_COOLDOWN_RAMP, '1);
    write_reg(rps_pkg::REG_DWELL_SECONDS, '1);
    phase_window(lo, hi);
    offer_time(TIN_W'(lo));
    offer_time(TIN_W'(hi));
    run_random(7, 50);
    phase_window(lo, hi);
    offer_time(TIN_W'(hi + 1));
  endtask

  task automatic test_dwell();
    int lo, hi;
    phase_window(lo, hi);
    offer_time(TIN_W'(lo));
    offer_time(TIN_W'(hi));
    offer_time('0);
    run_random(5, 50);
    phase_window(lo, hi);
    offer_time(TIN_W'(hi + 1));
  endtask

  task automatic test_cooldown();
    int lo, hi;
    wait_for_setpoints();
    write_reg(rps_pkg::REG_COOLDOWN_RAMP, '0);
    phase_window(lo, hi);
    offer_time(TIN_W'(lo));
    offer_time('0);           // far backward in time
    offer_time('1);           // far forward, clamps at zero
    // receiver holds off while samples keep coming, input must stall
    wait_for_setpoints();
    randomize_profile();
    burst_mode   = 1'b0;
    hold_off_req = 1'b1;
    repeat (30) offer_time(TIN_W'($urandom));
    run_random(7, 50);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main
    prof_preheat_temp  = rps_pkg::RST_PREHEAT_TEMP;
    prof_liquidus_temp = rps_pkg::RST_LIQUIDUS_TEMP;
    prof_peak_temp     = rps_pkg::RST_PEAK_TEMP;
    prof_preheat_ramp  = rps_pkg::RST_PREHEAT_RAMP;
    prof_cooldown_ramp = rps_pkg::RST_COOLDOWN_RAMP;
    prof_soak_seconds  = rps_pkg::RST_SOAK_SECONDS;
    prof_dwell_seconds = rps_pkg::RST_DWELL_SECONDS;
    prof_phase         = rps_pkg::PH_PREHEAT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_preheat();
    test_soak();
    test_reflow();
    test_dwell();
    test_cooldown();

    wait_for_setpoints();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_setpoints.size() == 0) begin
      $display("tb_reflow_profile_setpoint: PASS");
    end else begin
      $display("tb_reflow_profile_setpoint: FAIL");
    end
    $finish;
  end

endmodule
